@@ hw/rtl/mml_pkg.sv @@
// Shared types and constants for the matrix multiply layout unit.
// Used by mml_mac, mml_seq and the top level; depends on nothing.
`default_nettype none

package mml_pkg;

    // Fixed field widths of the item formats.
    localparam int DIM_BITS     = 5;
    localparam int INDEX_BITS   = 8;
    localparam int ELEM_IN_BITS = 24;
    localparam int CELL_BITS    = 4;
    localparam int VALUE_BITS   = 52;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    // Register indexes on the configuration port (paddr[3:2]).
    localparam logic [1:0] REG_MATRIX_SIZE    = 2'd0;
    localparam logic [1:0] REG_A_COLUMN_MAJOR = 2'd1;
    localparam logic [1:0] REG_B_COLUMN_MAJOR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } seq_state_t;

    // Sequencer to multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctrl_t;

    // Sequencer status toward the top level.
    typedef struct packed {
        logic idle;
        logic done;
        logic oor;
    } seq_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/mml_ram.sv @@
// Single-port-write, single-port-read element store with registered read data.
// Generic; depends on nothing.
`default_nettype none

module mml_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 24
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mml_mac.sv @@
// Shared multiply-accumulate unit: registered signed product, then a wrapping accumulator.
// Depends on mml_pkg for the control struct and the result width.
`default_nettype none

module mml_mac #(
    parameter int ELEM_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mml_pkg::mac_ctrl_t            ctrl,
    input  wire logic [ELEM_BITS-1:0]          a_data,
    input  wire logic [ELEM_BITS-1:0]          b_data,
    output logic      [mml_pkg::VALUE_BITS-1:0] acc,
    output logic                               busy
);
    import mml_pkg::*;

    localparam int PW = 2 * ELEM_BITS;

    logic signed [PW-1:0]            prod_reg;
    logic                            prod_v_reg;
    logic signed [PW+VALUE_BITS-1:0] prod_ext;
    logic [VALUE_BITS-1:0]           acc_reg;
    logic [VALUE_BITS-1:0]           acc_next;

    // The product is sign-extended, then cut to the result width so the sum wraps.
    assign prod_ext = (PW + VALUE_BITS)'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_v_reg)
        begin
            acc_next = acc_reg + prod_ext[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            prod_reg <= $signed(a_data) * $signed(b_data);
        end
        acc_reg <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = prod_v_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mml_seq.sv @@
// Sequencer for one product cell: walks k over the row of A and the column of B.
// Depends on mml_pkg for the state type and the control and status structs.
`default_nettype none

module mml_seq #(
    parameter int AW = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [mml_pkg::CELL_BITS-1:0]  row,
    input  wire logic [mml_pkg::CELL_BITS-1:0]  col,
    input  wire logic [mml_pkg::DIM_BITS-1:0]   n,
    input  wire logic                           a_col_major,
    input  wire logic                           b_col_major,
    input  wire logic                           out_free,
    input  wire logic                           prod_busy,
    output logic      [AW-1:0]                  addr_a,
    output logic      [AW-1:0]                  addr_b,
    output logic                                rd_en,
    output mml_pkg::mac_ctrl_t                  mac_ctrl,
    output mml_pkg::seq_status_t                status
);
    import mml_pkg::*;

    localparam int PROD_BITS = CELL_BITS + DIM_BITS;

    seq_state_t            state_reg;
    seq_state_t            state_next;
    logic [AW-1:0]         addr_a_reg;
    logic [AW-1:0]         addr_a_next;
    logic [AW-1:0]         addr_b_reg;
    logic [AW-1:0]         addr_b_next;
    logic [DIM_BITS-1:0]   step_a_reg;
    logic [DIM_BITS-1:0]   step_a_next;
    logic [DIM_BITS-1:0]   step_b_reg;
    logic [DIM_BITS-1:0]   step_b_next;
    logic [DIM_BITS-1:0]   k_reg;
    logic [DIM_BITS-1:0]   k_next;
    logic                  oor_reg;
    logic                  oor_next;
    logic                  rd_v_reg;
    logic [PROD_BITS-1:0]  row_times_n;
    logic [PROD_BITS-1:0]  col_times_n;
    logic                  req_oor;
    logic                  k_last;
    logic                  pipe_busy;

    assign row_times_n = {{DIM_BITS{1'b0}}, row} * {{CELL_BITS{1'b0}}, n};
    assign col_times_n = {{DIM_BITS{1'b0}}, col} * {{CELL_BITS{1'b0}}, n};
    assign req_oor     = ({1'b0, row} >= n) || ({1'b0, col} >= n);
    assign k_last      = (k_reg == (n - DIM_BITS'(1)));
    assign pipe_busy   = rd_v_reg || prod_busy;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = req_oor ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        rd_en          = 1'b0;
        mac_ctrl.clear = 1'b0;
        mac_ctrl.valid = rd_v_reg;
        status.idle    = 1'b0;
        status.done    = 1'b0;
        status.oor     = oor_reg;
        case (state_reg)
            ST_IDLE:
            begin
                status.idle    = 1'b1;
                mac_ctrl.clear = start;
            end
            ST_RUN:
            begin
                rd_en = 1'b1;
            end
            ST_DRAIN:
            begin
                rd_en = 1'b0;
            end
            ST_FINISH:
            begin
                status.done = out_free;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Address walk: A steps by one when row-major and by n when column-major; B the other way round.
    always_comb
    begin
        addr_a_next = addr_a_reg;
        addr_b_next = addr_b_reg;
        step_a_next = step_a_reg;
        step_b_next = step_b_reg;
        k_next      = k_reg;
        oor_next    = oor_reg;
        if ((state_reg == ST_IDLE) && start)
        begin
            addr_a_next = a_col_major ? AW'(row) : AW'(row_times_n);
            step_a_next = a_col_major ? n : DIM_BITS'(1);
            addr_b_next = b_col_major ? AW'(col_times_n) : AW'(col);
            step_b_next = b_col_major ? DIM_BITS'(1) : n;
            k_next      = '0;
            oor_next    = req_oor;
        end
        else if (state_reg == ST_RUN)
        begin
            addr_a_next = addr_a_reg + AW'(step_a_reg);
            addr_b_next = addr_b_reg + AW'(step_b_reg);
            k_next      = k_reg + DIM_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rd_v_reg  <= 1'b0;
            k_reg     <= '0;
            oor_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= rd_en;
            k_reg     <= k_next;
            oor_reg   <= oor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_a_reg <= addr_a_next;
        addr_b_reg <= addr_b_next;
        step_a_reg <= step_a_next;
        step_b_reg <= step_b_next;
    end

    assign addr_a = addr_a_reg;
    assign addr_b = addr_b_reg;

    // The accumulator is cleared only with nothing in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && start) |-> (!rd_v_reg && !prod_busy))
        else $error("accumulator cleared with a product in flight");

    // A result is handed over only after the last product has been added.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && !oor_reg) |-> !pipe_busy)
        else $error("result taken before the pipeline drained");

    // The walk over k never passes the matrix size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (k_reg < n))
        else $error("k ran past the matrix size");

endmodule

`default_nettype wire

@@ hw/rtl/matrix_multiply_layout_unit.sv @@
// Top level of the matrix multiply layout unit: stream ports, register file, element
// stores and output register. Depends on mml_pkg, mml_ram, mml_mac and mml_seq.
// A load gives no result. A compute walks the row of A and the column of B through the shared
// MAC, then hands its result to the output register once that is free; a cell outside the
// matrix skips the walk. No new item is taken until the compute has handed over its result.
// Reset (rst_n, async): n = 16, A row-, B col-major.
`default_nettype none

module matrix_multiply_layout_unit #(
    parameter int MAX_DIM   = 16,
    parameter int ELEM_BITS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // From bit 0: mem_index[7:0], element[31:8], cell_row[35:32], cell_col[39:36].
    input  wire logic [39:0] s_tdata,
    // From bit 0: op[1:0].
    input  wire logic [1:0]  s_tuser,
    // Result items.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // From bit 0: product_row[3:0], product_col[7:4], product_value[59:8], zero fill[63:60].
    output logic      [63:0] m_tdata,
    // From bit 0: out_of_range[0].
    output logic      [0:0]  m_tuser,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import mml_pkg::*;

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int AW      = $clog2(DEPTH);
    // The size register is 5 bits wide, so n can never exceed 31.
    localparam int DIM_CAP = (MAX_DIM > 31) ? 31 : MAX_DIM;

    // Register file.
    logic [DIM_BITS-1:0] matrix_size_reg;
    logic                a_column_major_reg;
    logic                b_column_major_reg;
    logic                cfg_write;

    // Unpacked input fields.
    logic [1:0]              in_op;
    logic [INDEX_BITS-1:0]   in_mem_index;
    logic [ELEM_IN_BITS-1:0] in_element;
    logic [CELL_BITS-1:0]    in_cell_row;
    logic [CELL_BITS-1:0]    in_cell_col;

    logic                    s_accept;
    logic [DIM_BITS-1:0]     dim_n;
    logic [2*DIM_BITS-1:0]   n_squared;
    logic                    load_ok;
    logic                    we_a;
    logic                    we_b;
    logic                    start;
    logic [ELEM_BITS+ELEM_IN_BITS-1:0] elem_ext;
    logic [ELEM_BITS-1:0]    store_wdata;

    logic [AW-1:0]           addr_a;
    logic [AW-1:0]           addr_b;
    logic                    rd_en;
    logic [ELEM_BITS-1:0]    a_data;
    logic [ELEM_BITS-1:0]    b_data;
    logic [VALUE_BITS-1:0]   acc;
    logic                    prod_busy;
    mac_ctrl_t               mac_ctrl;
    seq_status_t             seq_status;

    // Output register and the request cell it echoes.
    logic                    m_valid_reg;
    logic                    out_free;
    logic [CELL_BITS-1:0]    req_row_reg;
    logic [CELL_BITS-1:0]    req_col_reg;
    logic [CELL_BITS-1:0]    out_row_reg;
    logic [CELL_BITS-1:0]    out_col_reg;
    logic [VALUE_BITS-1:0]   out_value_reg;
    logic                    out_oor_reg;

    assign in_op        = s_tuser;
    assign in_mem_index = s_tdata[7:0];
    assign in_element   = s_tdata[31:8];
    assign in_cell_row  = s_tdata[35:32];
    assign in_cell_col  = s_tdata[39:36];

    // Configuration writes. Only paddr[3:2] selects the register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_size_reg    <= DIM_BITS'(16);
            a_column_major_reg <= 1'b0;
            b_column_major_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_MATRIX_SIZE:    matrix_size_reg    <= pwdata[DIM_BITS-1:0];
                REG_A_COLUMN_MAJOR: a_column_major_reg <= pwdata[0];
                REG_B_COLUMN_MAJOR: b_column_major_reg <= pwdata[0];
                default:            matrix_size_reg    <= matrix_size_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MATRIX_SIZE:    prdata = {{(32 - DIM_BITS){1'b0}}, matrix_size_reg};
            REG_A_COLUMN_MAJOR: prdata = {31'b0, a_column_major_reg};
            REG_B_COLUMN_MAJOR: prdata = {31'b0, b_column_major_reg};
            default:            prdata = 32'b0;
        endcase
    end

    // The size in use saturates at the largest dimension the stores hold.
    assign dim_n     = (matrix_size_reg > DIM_BITS'(DIM_CAP)) ? DIM_BITS'(DIM_CAP)
                                                              : matrix_size_reg;
    assign n_squared = {{DIM_BITS{1'b0}}, dim_n} * {{DIM_BITS{1'b0}}, dim_n};

    // Items are taken whenever the sequencer is idle; a pending result does not block loads.
    assign s_tready = seq_status.idle;
    assign s_accept = s_tvalid && s_tready;

    // A load beyond the n by n matrix is dropped, as is the unused op code.
    assign load_ok = ({{(2*DIM_BITS - INDEX_BITS){1'b0}}, in_mem_index} < n_squared);
    assign we_a    = s_accept && (in_op == OP_LOAD_A) && load_ok;
    assign we_b    = s_accept && (in_op == OP_LOAD_B) && load_ok;
    assign start   = s_accept && (in_op == OP_COMPUTE);

    // A narrower store keeps the low element bits; a wider one zero-fills above the field.
    assign elem_ext    = {{ELEM_BITS{1'b0}}, in_element};
    assign store_wdata = elem_ext[ELEM_BITS-1:0];

    mml_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_BITS)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (AW'(in_mem_index)),
        .wdata (store_wdata),
        .re    (rd_en),
        .raddr (addr_a),
        .rdata (a_data)
    );

    mml_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_BITS)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (AW'(in_mem_index)),
        .wdata (store_wdata),
        .re    (rd_en),
        .raddr (addr_b),
        .rdata (b_data)
    );

    mml_seq #(
        .AW (AW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .row         (in_cell_row),
        .col         (in_cell_col),
        .n           (dim_n),
        .a_col_major (a_column_major_reg),
        .b_col_major (b_column_major_reg),
        .out_free    (out_free),
        .prod_busy   (prod_busy),
        .addr_a      (addr_a),
        .addr_b      (addr_b),
        .rd_en       (rd_en),
        .mac_ctrl    (mac_ctrl),
        .status      (seq_status)
    );

    mml_mac #(
        .ELEM_BITS (ELEM_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a_data (a_data),
        .b_data (b_data),
        .acc    (acc),
        .busy   (prod_busy)
    );

    // The output register frees up in the same cycle its item is taken.
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (seq_status.done)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_row_reg <= in_cell_row;
            req_col_reg <= in_cell_col;
        end
        if (seq_status.done)
        begin
            out_row_reg   <= req_row_reg;
            out_col_reg   <= req_col_reg;
            out_value_reg <= seq_status.oor ? '0 : acc;
            out_oor_reg   <= seq_status.oor;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, out_value_reg, out_col_reg, out_row_reg};
    assign m_tuser  = out_oor_reg;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for matrix_multiply_layout_unit: loads, compute requests and
// register writes, with each product cell checked against an in-bench dot product model.
// Depends on mml_pkg and the RTL of the unit; reads no files.
`timescale 1ns / 1ps

module tb_top;

    import mml_pkg::*;

    localparam int MAX_DIM     = 16;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    // Cycles to let pass before a register write, after the last product cell has come.
    localparam int SETTLE_CYCLES = MAX_DIM + 8;
    // At the full size, product cells stay within the first rows and columns, so that only
    // part of each store has to be loaded.
    localparam int FULL_CELLS = 4;

    // Op code 3 has no meaning for the unit, so it must be dropped without a result.
    localparam logic [1:0]  OP_RESERVED = 2'd3;
    localparam logic [23:0] ELEM_MIN    = 24'h800000;
    localparam logic [23:0] ELEM_MAX    = 24'h7FFFFF;
    localparam logic [23:0] ELEM_ONE    = 24'h000001;
    localparam logic [23:0] ELEM_ALL1   = 24'hFFFFFF;
    localparam logic [23:0] ELEM_ZERO   = 24'h000000;

    // One product cell as it leaves the unit.
    typedef struct {
        logic [3:0]  row;
        logic [3:0]  col;
        logic [51:0] value;
        logic        oor;
    } cell_result_t;

    // Holds a private copy of both element stores and of the three registers, works out
    // the product cell for every accepted compute request, and checks the cells that come
    // out in order against that prediction.
    class product_scoreboard;
        logic signed [23:0] mat_a [STORE_DEPTH];
        logic signed [23:0] mat_b [STORE_DEPTH];
        logic [4:0]         size_reg;
        bit                 a_col_major;
        bit                 b_col_major;
        cell_result_t       cells_due[$];
        int                 errors;

        function new();
            size_reg    = 5'd16;
            a_col_major = 1'b0;
            b_col_major = 1'b1;
            errors      = 0;
        endfunction

        function void set_register(logic [1:0] index, logic [31:0] value);
            case (index)
                REG_MATRIX_SIZE:    size_reg = value[4:0];
                REG_A_COLUMN_MAJOR: a_col_major = value[0];
                REG_B_COLUMN_MAJOR: b_col_major = value[0];
                default: ;
            endcase
        endfunction

        // Sizes above the store dimension behave as the largest size.
        function int dim_in_use();
            return (size_reg > MAX_DIM) ? MAX_DIM : int'(size_reg);
        endfunction

        function int place(int r, int c, int n, bit col_major);
            return col_major ? (r + c * n) : (r * n + c);
        endfunction

        function logic [51:0] dot_product(int r, int c, int n);
            longint acc;
            int     k;
            acc = 0;
            for (k = 0; k < n; k++)
                acc += longint'(mat_a[place(r, k, n, a_col_major)])
                     * longint'(mat_b[place(k, c, n, b_col_major)]);
            return acc[51:0];
        endfunction

        function void note_item(logic [1:0] op, logic [7:0] idx, logic [23:0] elem,
                                logic [3:0] row, logic [3:0] col);
            cell_result_t due;
            int           n;
            n = dim_in_use();
            case (op)
                OP_LOAD_A: if (int'(idx) < n * n) mat_a[idx] = elem;
                OP_LOAD_B: if (int'(idx) < n * n) mat_b[idx] = elem;
                OP_COMPUTE:
                begin
                    due.row = row;
                    due.col = col;
                    if (int'(row) >= n || int'(col) >= n)
                    begin
                        due.value = '0;
                        due.oor   = 1'b1;
                    end
                    else
                    begin
                        due.value = dot_product(row, col, n);
                        due.oor   = 1'b0;
                    end
                    cells_due.push_back(due);
                end
                default: ;
            endcase
        endfunction

        function int pending();
            return cells_due.size();
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_cell(logic [3:0] row, logic [3:0] col, logic [51:0] value, logic oor);
            cell_result_t want;
            if (cells_due.size() == 0)
            begin
                report($sformatf("product cell (%0d,%0d) arrived with none outstanding",
                                 row, col));
                return;
            end
            want = cells_due.pop_front();
            if (row !== want.row)
                report($sformatf("product_row %0d, predicted %0d", row, want.row));
            if (col !== want.col)
                report($sformatf("product_col %0d, predicted %0d", col, want.col));
            if (value !== want.value)
                report($sformatf("cell (%0d,%0d) product_value %0h, predicted %0h",
                                 want.row, want.col, value, want.value));
            if (oor !== want.oor)
                report($sformatf("cell (%0d,%0d) out_of_range %0b, predicted %0b",
                                 want.row, want.col, oor, want.oor));
        endtask
    endclass

    // Every input of the unit holds a known value from time zero.
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;    // mem_index, element, cell_row, cell_col from bit 0
    logic [1:0]  s_tuser  = '0;    // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // product_row, product_col, product_value, zero fill
    logic [0:0]  m_tuser;          // out_of_range
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Idle rates in percent, changed by the stimulus between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    product_scoreboard sb = new();

    matrix_multiply_layout_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Result side: a cell is taken at every edge that sees tvalid and tready high, and
    // tready for the next edge is drawn from the current stall rate.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_cell(m_tdata[3:0], m_tdata[7:4], m_tdata[59:8], m_tuser[0]);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Setup cycle, then access cycle; the register takes the value at the edge where
    // psel, penable, pwrite and pready are all high.
    task automatic write_register(logic [1:0] index, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(index, value);
    endtask

    // Presents one item and holds it until the unit takes it. tvalid is only lowered
    // when a gap is drawn, so back-to-back items keep it high across the edge.
    task automatic send_item(logic [1:0] op, logic [7:0] idx, logic [23:0] elem,
                             logic [3:0] row, logic [3:0] col);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {col, row, elem, idx};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(op, idx, elem, row, col);
    endtask

    // Stops sending and waits until every predicted cell has been checked.
    task automatic drain_cells();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Loads carry no result, so the unit gets a few more cycles before a register moves.
    task automatic settle();
        drain_cells();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Element values lean toward the extremes and the values near zero.
    function automatic logic [23:0] random_element();
        case ($urandom_range(9))
            0: return ELEM_MIN;
            1: return ELEM_MAX;
            2: return ELEM_ALL1;
            3: return ELEM_ZERO;
            default: return 24'($urandom());
        endcase
    endfunction

    // Run once with the size at sixteen. Writes every entry that a product cell can reach:
    // the first FULL_CELLS rows and columns of the full size under either layout, which
    // also holds every entry of the sizes up to seven. Rows two and three of A row-major
    // and columns two and three of B column-major get the most negative value, so those
    // cells give the widest sum the unit can produce.
    task automatic fill_stores();
        int idx;
        bit extreme;
        for (idx = 0; idx < STORE_DEPTH; idx++)
        begin
            if (idx < MAX_DIM * FULL_CELLS || (idx % MAX_DIM) < FULL_CELLS)
            begin
                extreme = (idx >= MAX_DIM * (FULL_CELLS / 2)) && (idx < MAX_DIM * FULL_CELLS);
                send_item(OP_LOAD_A, 8'(idx), extreme ? ELEM_MIN : random_element(),
                          4'($urandom_range(15)), 4'($urandom_range(15)));
                send_item(OP_LOAD_B, 8'(idx), extreme ? ELEM_MIN : random_element(),
                          4'($urandom_range(15)), 4'($urandom_range(15)));
            end
        end
    endtask

    // Mixed traffic over filled stores: loads that overwrite entries, loads past n*n,
    // reserved op codes, and compute requests mostly inside the matrix. At the full size
    // cells stay within the first FULL_CELLS rows and columns. Only items that change the
    // store or produce a cell count toward the total.
    task automatic run_random(int count);
        int          n;
        int          cell_lim;
        int          done_items;
        int          pick;
        bit          counted;
        bit          paused;
        logic [1:0]  op;
        logic [7:0]  idx;
        logic [3:0]  row;
        logic [3:0]  col;
        n          = sb.dim_in_use();
        cell_lim   = (n >= MAX_DIM) ? FULL_CELLS : n;
        done_items = 0;
        paused     = 1'b0;
        while (done_items < count)
        begin
            pick = $urandom_range(99);
            idx  = 8'($urandom_range(255));
            row  = 4'($urandom_range(15));
            col  = 4'($urandom_range(15));
            if (pick < 36)
            begin
                op = pick[0] ? OP_LOAD_B : OP_LOAD_A;
                if (n > 0 && $urandom_range(99) < 85)
                    idx = 8'($urandom_range(n * n - 1));
                counted = (int'(idx) < n * n);
            end
            else if (pick < 41)
            begin
                op      = OP_RESERVED;
                counted = 1'b0;
            end
            else
            begin
                op = OP_COMPUTE;
                if (n >= MAX_DIM || (n > 0 && $urandom_range(99) < 85))
                begin
                    row = 4'($urandom_range(cell_lim - 1));
                    col = 4'($urandom_range(cell_lim - 1));
                end
                counted = 1'b1;
            end
            send_item(op, idx, random_element(), row, col);
            if (counted)
                done_items++;
            // Once per phase the sender holds off until the unit has emptied.
            if (!paused && done_items >= count / 2)
            begin
                paused = 1'b1;
                drain_cells();
            end
        end
    endtask

    task automatic run_phase(int size_val, bit a_cm, bit b_cm, bit fill_first,
                             int count, int idle_mode);
        case (idle_mode)
            0:
            begin
                send_idle_pct = 23;
                recv_idle_pct = 46;
            end
            1:
            begin
                send_idle_pct = 46;
                recv_idle_pct = 23;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
        write_register(REG_MATRIX_SIZE, size_val);
        write_register(REG_A_COLUMN_MAJOR, 32'(a_cm));
        write_register(REG_B_COLUMN_MAJOR, 32'(b_cm));
        if (fill_first)
            fill_stores();
        run_random(count);
        settle();
    endtask

    // Two by two matrices with A column-major and B row-major. A holds the most negative,
    // the most positive, minus one and zero; B mixes the extremes with one. Then come
    // loads past n*n, the four cells inside, cells outside the matrix, a reserved op code,
    // and finally both stores at the most negative value for the largest cell this size can give.
    task automatic run_directed();
        int idx;
        send_idle_pct = 23;
        recv_idle_pct = 46;
        write_register(REG_MATRIX_SIZE, 2);
        write_register(REG_A_COLUMN_MAJOR, 1);
        write_register(REG_B_COLUMN_MAJOR, 0);
        send_item(OP_LOAD_A, 0, ELEM_MIN, 0, 0);
        send_item(OP_LOAD_A, 1, ELEM_MAX, 0, 0);
        send_item(OP_LOAD_A, 2, ELEM_ALL1, 0, 0);
        send_item(OP_LOAD_A, 3, ELEM_ZERO, 0, 0);
        send_item(OP_LOAD_B, 0, ELEM_MAX, 0, 0);
        send_item(OP_LOAD_B, 1, ELEM_MIN, 0, 0);
        send_item(OP_LOAD_B, 2, ELEM_ONE, 0, 0);
        send_item(OP_LOAD_B, 3, ELEM_MIN, 0, 0);
        // Index n*n and the top index must leave the stores alone.
        send_item(OP_LOAD_A, 4, ELEM_MAX, 0, 0);
        send_item(OP_LOAD_B, 255, ELEM_MAX, 15, 15);
        send_item(OP_COMPUTE, 0, ELEM_ZERO, 0, 0);
        send_item(OP_COMPUTE, 0, ELEM_ZERO, 0, 1);
        send_item(OP_COMPUTE, 0, ELEM_ZERO, 1, 0);
        send_item(OP_COMPUTE, 0, ELEM_ZERO, 1, 1);
        send_item(OP_COMPUTE, 0, ELEM_ZERO, 2, 0);
        send_item(OP_COMPUTE, 0, ELEM_ZERO, 0, 15);
        send_item(OP_COMPUTE, 255, ELEM_ALL1, 15, 15);
        send_item(OP_RESERVED, 255, ELEM_ALL1, 15, 15);
        for (idx = 0; idx < 4; idx++)
        begin
            send_item(OP_LOAD_A, 8'(idx), ELEM_MIN, 0, 0);
            send_item(OP_LOAD_B, 8'(idx), ELEM_MIN, 0, 0);
        end
        send_item(OP_COMPUTE, 0, ELEM_ZERO, 1, 1);
        settle();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Sizes run from zero through one and mid values to sixteen, plus a value past
        // sixteen that must act as sixteen; the layouts take all four pairings. The first
        // sixteen phase loads both stores once; the sizes used stay at seven or below or
        // at the full size, so every cell reads only loaded entries.
        run_phase(16, 1'b0, 1'b1, 1'b1, 30, 0);
        run_phase(1,  1'b0, 1'b0, 1'b0, 20, 0);
        run_phase(5,  1'b1, 1'b1, 1'b0, 25, 0);
        run_phase(0,  1'b1, 1'b0, 1'b0, 15, 1);
        run_phase(31, 1'b1, 1'b0, 1'b0, 30, 1);
        run_phase(7,  1'b0, 1'b1, 1'b0, 25, 1);
        run_phase(16, 1'b0, 1'b0, 1'b0, 30, 2);
        run_phase(3,  1'b1, 1'b1, 1'b0, 20, 2);

        // settle() has already waited for the last cell; anything still listed was lost.
        if (sb.pending() != 0)
            sb.report($sformatf("%0d product cells never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Upper bound on the run: far beyond the slowest correct run with every stall.
    initial
    begin
        #5_000_000;
        $display("[%0t] TIMEOUT: run did not finish", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ matrix_multiply_layout_unit.f @@
hw/rtl/mml_pkg.sv
hw/rtl/mml_ram.sv
hw/rtl/mml_mac.sv
hw/rtl/mml_seq.sv
hw/rtl/matrix_multiply_layout_unit.sv
sim/tb_top.sv
